@@ design/lbtc_pkg.sv @@
// Shared types and constants for the LED blink and timeout controller.
// Used by the top level, the entry RAM user logic and the port checker.
package lbtc_pkg;

  localparam int unsigned NumLedsDef = 4;
  localparam int unsigned TickMsDef  = 500;

  // Request function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CFG  = 1'b1;

  // LED mode codes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_FLASH = 2'd2;

  // Drive codes
  localparam logic [1:0] DRIVE_OFF    = 2'd0;
  localparam logic [1:0] DRIVE_ON     = 2'd1;
  localparam logic [1:0] DRIVE_TOGGLE = 2'd2;

  localparam logic [15:0] HOLD_FOREVER = 16'hFFFF;
  localparam logic [7:0]  ENDLESS      = 8'hFF;

  typedef struct packed {
    logic        func;
    logic [3:0]  led_index;
    logic [1:0]  mode;
    logic [15:0] timeout_ms;
    logic [15:0] flash_period_ms;
    logic [7:0]  flash_count;
  } in_req_t;

  typedef struct packed {
    logic [3:0] led_number;
    logic [1:0] drive;
    logic       last;
  } out_res_t;

  // One LED entry as held in the entry RAM
  typedef struct packed {
    logic [1:0]  led_mode;
    logic        led_level;
    logic [15:0] toggle_countdown;
    logic [15:0] toggle_period;
    logic [7:0]  toggles_left;
    logic [15:0] hold_limit;
    logic [15:0] hold_countdown;
  } entry_t;

endpackage

@@ design/lbtc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lbtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/led_blink_timeout_controller_top.sv @@
// A configure request moves its result through the pending slot into the output
// register. A tick request walks the entry RAM, one LED per cycle unless a result
// waits on a stalled output, and its last result leaves through the same path.
// Only one request is taken at a time; the single read and write port of the
// entry RAM sets the walk rate.
// Reset clears the per-entry valid bits at once: every LED then reads as off.
module led_blink_timeout_controller_top #(
  parameter int unsigned NUM_LEDS = lbtc_pkg::NumLedsDef,
  parameter int unsigned TICK_MS  = lbtc_pkg::TickMsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lbtc_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbtc_pkg::out_res_t out_res_o
);

  localparam int unsigned IdxW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned EntryW = $bits(lbtc_pkg::entry_t);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_LEDS - 1);
  localparam logic [15:0] Step = 16'(TICK_MS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_FLUSH
  } state_e;

  state_e             state_q;
  logic [IdxW-1:0]    idx_q;
  logic [NUM_LEDS-1:0] vld_q;
  logic               pend_valid_q;
  logic [3:0]         pend_led_q;
  logic [1:0]         pend_drive_q;
  logic               out_valid_q;
  lbtc_pkg::out_res_t out_res_q;

  logic               accept;
  logic               cfg_hit;
  logic               out_free;
  logic               out_load;
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  lbtc_pkg::entry_t   ram_wdata;
  logic               ram_re;
  logic [IdxW-1:0]    ram_raddr;
  logic [EntryW-1:0]  ram_rdata;

  lbtc_pkg::entry_t   cur;
  lbtc_pkg::entry_t   upd;
  lbtc_pkg::entry_t   cfg_entry;
  logic [1:0]         cfg_drive;
  logic               res_valid;
  logic [1:0]         res_drive;
  logic [15:0]        cd_next;
  logic               mod_hold;
  logic               mod_go;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_hit    = ({1'b0, in_req_i.led_index} < 5'(NUM_LEDS));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Build a fresh entry for a configure request
  always_comb begin
    cfg_entry          = '0;
    cfg_entry.led_mode = in_req_i.mode;
    cfg_drive          = lbtc_pkg::DRIVE_OFF;
    if (in_req_i.mode == lbtc_pkg::MODE_FLASH) begin
      cfg_entry.toggle_period    = in_req_i.flash_period_ms;
      cfg_entry.toggle_countdown = in_req_i.flash_period_ms;
      cfg_entry.toggles_left     = {in_req_i.flash_count[6:0], 1'b0} - 8'd1;
      cfg_entry.led_level        = 1'b1;
      cfg_drive                  = lbtc_pkg::DRIVE_TOGGLE;
    end else begin
      cfg_entry.hold_limit     = in_req_i.timeout_ms;
      cfg_entry.hold_countdown = in_req_i.timeout_ms;
      if (in_req_i.mode == lbtc_pkg::MODE_ON) begin
        cfg_entry.led_level = 1'b1;
        cfg_drive           = lbtc_pkg::DRIVE_ON;
      end
    end
  end

  // Count down one tick on the entry just read
  always_comb begin
    cur       = vld_q[idx_q] ? lbtc_pkg::entry_t'(ram_rdata) : '0;
    upd       = cur;
    res_valid = 1'b0;
    res_drive = lbtc_pkg::DRIVE_OFF;
    if (cur.led_mode == lbtc_pkg::MODE_FLASH) begin
      cd_next = (cur.toggle_countdown >= Step) ? cur.toggle_countdown - Step : '0;
      upd.toggle_countdown = cd_next;
      if (cd_next == '0) begin
        upd.led_level        = !cur.led_level;
        upd.toggle_countdown = cur.toggle_period;
        if (cur.toggles_left != lbtc_pkg::ENDLESS) begin
          upd.toggles_left = cur.toggles_left - 8'd1;
          if (cur.toggles_left == 8'd1) begin
            upd.led_mode = lbtc_pkg::MODE_OFF;
          end
        end
        res_valid = 1'b1;
        res_drive = cur.led_level ? lbtc_pkg::DRIVE_OFF : lbtc_pkg::DRIVE_ON;
      end
    end else begin
      cd_next = (cur.hold_countdown >= Step) ? cur.hold_countdown - Step : '0;
      upd.hold_countdown = cd_next;
      if (cd_next == '0 && cur.hold_limit != lbtc_pkg::HOLD_FOREVER && cur.led_level) begin
        upd.led_level = 1'b0;
        res_valid     = 1'b1;
      end
    end
  end

  // Wait in the walk when a pending result cannot move to the output
  assign mod_hold = res_valid && pend_valid_q && !out_free;
  assign mod_go   = (state_q == S_MOD) && !mod_hold;

  // Load the output register from the pending slot
  assign out_load = pend_valid_q && out_free &&
                    ((mod_go && res_valid) || (state_q == S_FLUSH));

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = upd;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (accept && in_req_i.func == lbtc_pkg::FUNC_CFG && cfg_hit) begin
      ram_we    = 1'b1;
      ram_waddr = in_req_i.led_index[IdxW-1:0];
      ram_wdata = cfg_entry;
    end else if (accept && in_req_i.func == lbtc_pkg::FUNC_TICK) begin
      ram_re = 1'b1;
    end else if (mod_go) begin
      ram_we = 1'b1;
      if (idx_q != LastIdx) begin
        ram_re    = 1'b1;
        ram_raddr = idx_q + IdxW'(1);
      end
    end
  end

  lbtc_ram #(
    .WIDTH (EntryW),
    .DEPTH (NUM_LEDS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold state, walk index, pending result and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      vld_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_led_q   <= '0;
      pend_drive_q <= lbtc_pkg::DRIVE_OFF;
      out_valid_q  <= 1'b0;
      out_res_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_req_i.func == lbtc_pkg::FUNC_TICK) begin
              idx_q   <= '0;
              state_q <= S_MOD;
            end else if (cfg_hit) begin
              pend_valid_q <= 1'b1;
              pend_led_q   <= in_req_i.led_index;
              pend_drive_q <= cfg_drive;
              state_q      <= S_FLUSH;
            end
          end
        end
        S_MOD: begin
          if (mod_go) begin
            if (res_valid) begin
              // Push the older result out, keep the new one back
              if (pend_valid_q) begin
                out_res_q <= '{led_number: pend_led_q, drive: pend_drive_q, last: 1'b0};
              end
              pend_valid_q <= 1'b1;
              pend_led_q   <= 4'(idx_q);
              pend_drive_q <= res_drive;
            end
            if (idx_q == LastIdx) begin
              state_q <= S_FLUSH;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_res_q    <= '{led_number: pend_led_q, drive: pend_drive_q, last: 1'b1};
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

@@ design/lbtc_checker.sv @@
// Port-level assertions for the LED blink and timeout controller.
// Depends on lbtc_pkg; bound to the top level below.
module lbtc_checker #(
  parameter int unsigned NUM_LEDS = lbtc_pkg::NumLedsDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lbtc_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lbtc_pkg::out_res_t out_res_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  // A toggle comes only from a configure request, which gives one result
  a_toggle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.drive == lbtc_pkg::DRIVE_TOGGLE |-> out_res_o.last)
    else $error("toggle result without last flag");

  // Results name only existing LEDs
  a_led_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_res_o.led_number} < 5'(NUM_LEDS)))
    else $error("result for an LED out of range");

endmodule

bind led_blink_timeout_controller_top lbtc_checker #(
  .NUM_LEDS (NUM_LEDS)
) u_lbtc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
